>>> rtl/ple_pkg.sv
package ple_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 16;

	// request kinds
	typedef enum logic [1:0] {
		REQ_APPEND  = 2'd0,
		REQ_INSERT  = 2'd1,
		REQ_DELETE  = 2'd2,
		REQ_REVERSE = 2'd3
	} req_type_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_RD,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_WR,
		S_SWAP_RD,
		S_SWAP_WA,
		S_SWAP_WB,
		S_DUMP_START,
		S_DUMP_RD,
		S_DUMP_LD,
		S_OUT_WAIT
	} state_t;

	// index register operations
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_COUNT,
		IDX_POSM1,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		HI_HOLD,
		HI_LOAD,
		HI_DEC
	} hi_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// read address for port a (port b always reads the upper swap index)
	typedef enum logic [1:0] {
		RA_IDX,
		RA_IDXM1,
		RA_IDXP1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_COUNT,
		WA_IDX,
		WA_POS,
		WA_HI
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_VALUE,
		WD_RDA,
		WD_RDB
	} wd_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic      req_ld;
		logic      st_ld;
		status_t   st_code;
		idx_op_t   idx_op;
		hi_op_t    hi_op;
		cnt_op_t   cnt_op;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wa_sel_t   wa_sel;
		wd_sel_t   wd_sel;
		logic      out_ld;
		logic      out_empty;
	} dp_cmd_t;

	// flags from datapath to controller
	typedef struct packed {
		req_type_t req_type;
		logic      full;
		logic      pos_gt_n;
		logic      pos_zero;
		logic      n_gt1;
		logic      n_zero;
		logic      idx_gt_pos;
		logic      idx_next_lt_n;
		logic      lo_lt_hi;
		logic      out_last;
	} dp_flags_t;

endpackage

>>> rtl/positional_list_engine_core.sv
// positional list engine: ordered list of up to CAPACITY signed 32-bit values
// input channel (in_valid/in_ready) takes one request word: req_type, value,
// position. kinds are append, insert after position (0 is the head), delete
// at a 1-based position and reverse
// after each request the list is dumped on the output channel (out_valid/
// out_ready), one word per element head to tail, last set on the final word;
// an empty list gives one word with empty_res set. every word of a dump
// carries the request status: ok, position out of range or list full
// one request at a time: in_ready is high only while idle
// steps, paced by the single write port of the element store:
//   decode; insert reads then writes each entry moved up, then writes the value;
//   delete reads then writes each entry moved down; reverse reads each pair,
//   then writes both ends; dump starts, then per word: read, load, hand over
// a stalled receiver holds the current word; the engine waits with it
// reset clears the element count, so the list starts empty; the store
// itself is not cleared and needs no clearing pass
module positional_list_engine_core
	import ple_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] elem_value,
	output logic [1:0]              status,
	output logic                    empty_res,
	output logic                    last
);

	dp_cmd_t   cmd;
	dp_flags_t flags;

	// sequencer
	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// element store, counters and output word
	ple_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.flags      (flags),
		.req_type   (req_type),
		.value      (value),
		.position   (position),
		.elem_value (elem_value),
		.status     (status),
		.empty_res  (empty_res),
		.last       (last)
	);

endmodule

>>> rtl/ple_dp.sv
module ple_dp
	import ple_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_flags_t               flags,
	input  logic [1:0]              req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic signed [VAL_W-1:0] elem_value,
	output logic [1:0]              status,
	output logic                    empty_res,
	output logic                    last
);

	// request registers
	req_type_t               req_type_q;
	logic [VAL_W-1:0]        value_q;
	logic [POS_W-1:0]        pos_q;
	status_t                 status_q;

	// list control
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        hi_q;
	logic [CNT_W-1:0]        idx_p1;
	logic [CNT_W-1:0]        idx_m1;

	// element store and its registered read ports
	logic [VAL_W-1:0]        mem [CAPACITY];
	logic [VAL_W-1:0]        rd_a_q;
	logic [VAL_W-1:0]        rd_b_q;
	logic [ADDR_W-1:0]       ra;
	logic [ADDR_W-1:0]       wa;
	logic [VAL_W-1:0]        wd;

	// output word
	logic [VAL_W-1:0]        out_val_q;
	logic                    out_empty_q;
	logic                    out_last_q;

	assign idx_p1 = idx_q + 1'b1;
	assign idx_m1 = idx_q - 1'b1;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.req_ld) begin
			req_type_q <= req_type_t'(req_type);
			value_q    <= value;
			pos_q      <= position;
		end
		if (cmd.st_ld) begin
			status_q <= cmd.st_code;
		end
	end

	// count, index and upper swap index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + 1'b1;
				CNT_DEC: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.idx_op)
			IDX_ZERO:  idx_q <= '0;
			IDX_COUNT: idx_q <= count_q;
			IDX_POSM1: idx_q <= CNT_W'(pos_q - 1'b1);
			IDX_INC:   idx_q <= idx_p1;
			IDX_DEC:   idx_q <= idx_m1;
			default:   idx_q <= idx_q;
		endcase
		unique case (cmd.hi_op)
			HI_LOAD: hi_q <= count_q - 1'b1;
			HI_DEC:  hi_q <= hi_q - 1'b1;
			default: hi_q <= hi_q;
		endcase
	end

	// address and data selection
	always_comb begin
		unique case (cmd.rd_sel)
			RA_IDXM1: ra = idx_m1[ADDR_W-1:0];
			RA_IDXP1: ra = idx_p1[ADDR_W-1:0];
			default:  ra = idx_q[ADDR_W-1:0];
		endcase
		unique case (cmd.wa_sel)
			WA_COUNT: wa = count_q[ADDR_W-1:0];
			WA_POS:   wa = pos_q[ADDR_W-1:0];
			WA_HI:    wa = hi_q[ADDR_W-1:0];
			default:  wa = idx_q[ADDR_W-1:0];
		endcase
		unique case (cmd.wd_sel)
			WD_RDA:  wd = rd_a_q;
			WD_RDB:  wd = rd_b_q;
			default: wd = value_q;
		endcase
	end

	// element store
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_a_q <= mem[ra];
			rd_b_q <= mem[hi_q[ADDR_W-1:0]];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (cmd.out_empty) begin
				out_val_q   <= '0;
				out_empty_q <= 1'b1;
				out_last_q  <= 1'b1;
			end else begin
				out_val_q   <= rd_a_q;
				out_empty_q <= 1'b0;
				out_last_q  <= (idx_p1 == count_q);
			end
		end
	end

	// flags for the controller
	always_comb begin
		flags.req_type      = req_type_q;
		flags.full          = (count_q == CNT_W'(CAPACITY));
		flags.pos_gt_n      = (pos_q > POS_W'(count_q));
		flags.pos_zero      = (pos_q == '0);
		flags.n_gt1         = (count_q > CNT_W'(1));
		flags.n_zero        = (count_q == '0);
		flags.idx_gt_pos    = (POS_W'(idx_q) > pos_q);
		flags.idx_next_lt_n = (idx_p1 < count_q);
		flags.lo_lt_hi      = (idx_q < hi_q);
		flags.out_last      = out_last_q;
	end

	assign elem_value = out_val_q;
	assign status     = status_q;
	assign empty_res  = out_empty_q;
	assign last       = out_last_q;

endmodule

>>> rtl/ple_ctrl.sv
module ple_ctrl
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_flags_t flags,
	output dp_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.req_ld = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.st_ld   = 1'b1;
				cmd.st_code = ST_OK;
				state_d     = S_DUMP_START;
				unique case (flags.req_type)
					REQ_APPEND: begin
						if (flags.full) begin
							cmd.st_code = ST_FULL;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = WA_COUNT;
							cmd.wd_sel = WD_VALUE;
							cmd.cnt_op = CNT_INC;
						end
					end
					REQ_INSERT: begin
						if (flags.pos_gt_n) begin
							cmd.st_code = ST_RANGE;
						end else if (flags.full) begin
							cmd.st_code = ST_FULL;
						end else begin
							cmd.idx_op = IDX_COUNT;
							state_d    = S_INS_RD;
						end
					end
					REQ_DELETE: begin
						if (flags.pos_zero || flags.pos_gt_n) begin
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.idx_op = IDX_POSM1;
							state_d    = S_DEL_RD;
						end
					end
					REQ_REVERSE: begin
						if (flags.n_gt1) begin
							cmd.idx_op = IDX_ZERO;
							cmd.hi_op  = HI_LOAD;
							state_d    = S_SWAP_RD;
						end
					end
					default: state_d = S_DUMP_START;
				endcase
			end
			// insert: move entries up one place from the tail, then drop in the value
			S_INS_RD: begin
				if (flags.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDXM1;
					state_d    = S_INS_WR;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_POS;
					cmd.wd_sel = WD_VALUE;
					cmd.cnt_op = CNT_INC;
					state_d    = S_DUMP_START;
				end
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_IDX;
				cmd.wd_sel = WD_RDA;
				cmd.idx_op = IDX_DEC;
				state_d    = S_INS_RD;
			end
			// delete: close the gap by moving later entries down
			S_DEL_RD: begin
				if (flags.idx_next_lt_n) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDXP1;
					state_d    = S_DEL_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_DUMP_START;
				end
			end
			S_DEL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_IDX;
				cmd.wd_sel = WD_RDA;
				cmd.idx_op = IDX_INC;
				state_d    = S_DEL_RD;
			end
			// reverse: swap the outer pair and move inwards
			S_SWAP_RD: begin
				if (flags.lo_lt_hi) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_d    = S_SWAP_WA;
				end else begin
					state_d = S_DUMP_START;
				end
			end
			S_SWAP_WA: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_IDX;
				cmd.wd_sel = WD_RDB;
				state_d    = S_SWAP_WB;
			end
			S_SWAP_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_HI;
				cmd.wd_sel = WD_RDA;
				cmd.idx_op = IDX_INC;
				cmd.hi_op  = HI_DEC;
				state_d    = S_SWAP_RD;
			end
			// dump the list head to tail
			S_DUMP_START: begin
				if (flags.n_zero) begin
					cmd.out_ld    = 1'b1;
					cmd.out_empty = 1'b1;
					state_d       = S_OUT_WAIT;
				end else begin
					cmd.idx_op = IDX_ZERO;
					state_d    = S_DUMP_RD;
				end
			end
			S_DUMP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_IDX;
				state_d    = S_DUMP_LD;
			end
			S_DUMP_LD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (flags.out_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_DUMP_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> tb/positional_list_engine_core_test.sv
`timescale 1ns / 100ps

module positional_list_engine_core_test;
	import ple_pkg::*;

	localparam int RANDOM_REQS  = 200;
	localparam int TAIL_LEN     = 20;
	localparam int DRAIN_CYCLES = 32;
	// watchdog limit for the whole run
	localparam int CYCLE_LIMIT  = 800_000;

	typedef struct packed {
		req_type_t               kind;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0]        pos;
	} list_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] elem;
		status_t                 st;
		logic                    empty_mark;
		logic                    last_mark;
	} dump_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              req_type = REQ_APPEND;
	logic signed [VAL_W-1:0] value = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] elem_value;
	logic [1:0]              status;
	logic                    empty_res;
	logic                    last;

	list_req_t               req_backlog[$];
	dump_word_t              dump_due[$];
	list_req_t               next_req;
	logic signed [VAL_W-1:0] list_mem [CAPACITY];
	int                      list_len = 0;
	int                      plan_len = 0;
	int                      send_gap = 0;
	int                      hold_left = 0;
	int                      fail_count = 0;
	int                      cycle_count = 0;

	positional_list_engine_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.elem_value (elem_value),
		.status     (status),
		.empty_res  (empty_res),
		.last       (last)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// list model: apply one request and queue the dump it produces
	function automatic void apply_request(req_type_t kind, logic signed [VAL_W-1:0] val,
			logic [POS_W-1:0] pos);
		status_t                 st;
		int                      n;
		int                      p;
		int                      i;
		logic signed [VAL_W-1:0] swap_tmp;
		dump_word_t              w;
		st = ST_OK;
		n = list_len;
		p = pos;
		case (kind)
			REQ_APPEND: begin
				if (n >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					list_mem[n] = val;
					n++;
				end
			end
			REQ_INSERT: begin
				// range is checked before fullness
				if (p > n) begin
					st = ST_RANGE;
				end else if (n >= CAPACITY) begin
					st = ST_FULL;
				end else begin
					for (i = n; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					n++;
				end
			end
			REQ_DELETE: begin
				if (p == 0 || p > n) begin
					st = ST_RANGE;
				end else begin
					for (i = p - 1; i + 1 < n; i++)
						list_mem[i] = list_mem[i+1];
					n--;
				end
			end
			default: begin
				for (i = 0; i < n / 2; i++) begin
					swap_tmp = list_mem[i];
					list_mem[i] = list_mem[n-1-i];
					list_mem[n-1-i] = swap_tmp;
				end
			end
		endcase
		list_len = n;

		// dump, head to tail, or one empty marker
		if (n == 0) begin
			w.elem = '0;
			w.st = st;
			w.empty_mark = 1'b1;
			w.last_mark = 1'b1;
			dump_due = {dump_due, w};
		end else begin
			for (i = 0; i < n; i++) begin
				w.elem = list_mem[i];
				w.st = st;
				w.empty_mark = 1'b0;
				w.last_mark = (i == n - 1);
				dump_due = {dump_due, w};
			end
		end
	endfunction

	// queue one request and follow the list length it will leave
	function automatic void queue_req(req_type_t kind, logic [VAL_W-1:0] val, int pos);
		list_req_t r;
		r.kind = kind;
		r.val = val;
		r.pos = pos[POS_W-1:0];
		req_backlog = {req_backlog, r};
		case (kind)
			REQ_APPEND:
				if (plan_len < CAPACITY) plan_len++;
			REQ_INSERT:
				if (r.pos <= plan_len && plan_len < CAPACITY) plan_len++;
			REQ_DELETE:
				if (r.pos != 0 && r.pos <= plan_len) plan_len--;
			default: ;
		endcase
	endfunction

	// request driver, with random send gaps except near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_APPEND;
			value <= '0;
			position <= '0;
			send_gap <= 0;
		end else begin
			// a word taken at this edge updates the list model
			if (in_valid && in_ready)
				apply_request(req_type_t'(req_type), value, position);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					in_valid <= 1'b0;
				end else if (req_backlog.size() > TAIL_LEN && $urandom_range(0, 3) == 0) begin
					send_gap <= $urandom_range(0, 4);
					in_valid <= 1'b0;
				end else begin
					next_req = req_backlog.pop_front();
					req_type <= next_req.kind;
					value <= next_req.val;
					position <= next_req.pos;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// dump monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (dump_due.size() == 0) begin
					$error("unexpected dump word: elem_value %0d", elem_value);
					fail_count++;
				end else begin
					if (elem_value !== dump_due[0].elem) begin
						$error("elem_value: expected %0d, got %0d", dump_due[0].elem, elem_value);
						fail_count++;
					end
					if (status !== dump_due[0].st) begin
						$error("status: expected %0d, got %0d", dump_due[0].st, status);
						fail_count++;
					end
					if (empty_res !== dump_due[0].empty_mark) begin
						$error("empty_res: expected %0d, got %0d",
							dump_due[0].empty_mark, empty_res);
						fail_count++;
					end
					if (last !== dump_due[0].last_mark) begin
						$error("last: expected %0d, got %0d", dump_due[0].last_mark, last);
						fail_count++;
					end
					void'(dump_due.pop_front());
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (req_backlog.size() > TAIL_LEN && $urandom_range(0, 3) == 0) begin
				hold_left <= $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("positional_list_engine_core regression: fail");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int  k;
		int  pick;
		int  full_hits;
		bit  growing;
		full_hits = 0;
		growing = 1'b1;

		// empty list handling
		queue_req(REQ_REVERSE, 32'h1234_5678, 0);
		queue_req(REQ_DELETE, 0, 0);
		queue_req(REQ_DELETE, 0, 1);
		queue_req(REQ_INSERT, 7, 1);
		// head insert into empty list, single element reverse
		queue_req(REQ_INSERT, 32'h8000_0000, 0);
		queue_req(REQ_REVERSE, 0, 16'hFFFF);
		queue_req(REQ_APPEND, 32'h7FFF_FFFF, 0);
		queue_req(REQ_APPEND, 0, 16'hFFFF);
		queue_req(REQ_APPEND, 32'hFFFF_FFFF, 0);
		queue_req(REQ_INSERT, 1234, 0);
		// insert at the tail, in the middle, and past the end
		queue_req(REQ_INSERT, -55, 5);
		queue_req(REQ_INSERT, 99, 2);
		queue_req(REQ_INSERT, 42, 8);
		queue_req(REQ_INSERT, 42, 16'hFFFF);
		// odd and even length reverse
		queue_req(REQ_REVERSE, 0, 0);
		queue_req(REQ_APPEND, 32'h5A5A_A5A5, 0);
		queue_req(REQ_REVERSE, 32'hFFFF_FFFF, 3);
		// deletes: zero position, head, tail, past the end
		queue_req(REQ_DELETE, 0, 0);
		queue_req(REQ_DELETE, 32'hDEAD_BEEF, 1);
		queue_req(REQ_DELETE, 0, 7);
		queue_req(REQ_DELETE, 0, 7);
		queue_req(REQ_DELETE, 0, 16'hFFFF);

		// random: grow to full, sit at full a while, shrink to empty, repeat
		for (k = 0; k < RANDOM_REQS; k++) begin
			if (plan_len == CAPACITY && growing) begin
				full_hits++;
				if (full_hits > 4) begin
					growing = 1'b0;
					full_hits = 0;
				end
			end
			if (plan_len == 0)
				growing = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				queue_req(req_type_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 16'hFFFF));
			end else if (pick < 16) begin
				queue_req(REQ_REVERSE, $urandom, $urandom_range(0, 16'hFFFF));
			end else if (growing ? pick < 88 : pick < 30) begin
				if ($urandom_range(0, 1))
					queue_req(REQ_APPEND, $urandom, $urandom_range(0, 16'hFFFF));
				else if ($urandom_range(0, 7) == 0)
					queue_req(REQ_INSERT, $urandom, plan_len + 1);
				else
					queue_req(REQ_INSERT, $urandom, $urandom_range(0, plan_len));
			end else begin
				queue_req(REQ_DELETE, $urandom, $urandom_range(1, plan_len));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || in_valid || dump_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("positional_list_engine_core regression: pass");
		else
			$display("positional_list_engine_core regression: fail");
		$finish;
	end

endmodule
